// ===== src/b2da_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and state codes for the binary to decimal ascii converter
// no dependencies

package b2da_pkg;

    localparam int VALUE_BITS = 64;
    localparam int MAX_DIGITS = 20;
    localparam int BCD_BITS   = MAX_DIGITS * 4;
    localparam int BIT_CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);

    localparam logic [5:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

    // commands to the bcd digit register
    typedef struct packed {
        logic clear;
        logic dabble;
        logic bit_in;
        logic shift_digit;
    } t_bcd_ctrl;

endpackage

// ===== src/b2da_bcd_shift.sv =====
`timescale 1ns / 1ps
// bcd digit register: shift-add-3 conversion one bit per cycle, then digit-wise unload
// depends on b2da_pkg

module b2da_bcd_shift (
    input  logic                i_clk,
    input  b2da_pkg::t_bcd_ctrl i_ctrl,
    output logic [3:0]          o_top_digit
);
    import b2da_pkg::*;

    logic [BCD_BITS-1:0] r_bcd;
    logic [BCD_BITS-1:0] n_bcd;
    logic [BCD_BITS-1:0] w_adj;

    // each digit lane adds 3 when it is 5 or more, before the shift
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                w_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                w_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    always_comb begin
        n_bcd = r_bcd;
        if (i_ctrl.clear) begin
            n_bcd = '0;
        end else if (i_ctrl.dabble) begin
            n_bcd = {w_adj[BCD_BITS-2:0], i_ctrl.bit_in};
        end else if (i_ctrl.shift_digit) begin
            n_bcd = r_bcd << 4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
    end

    assign o_top_digit = r_bcd[BCD_BITS-1 -: 4];

endmodule

// ===== src/binary_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// sequence: load, bit-serial shift-add-3 over all VALUE_BITS (64) bits, then a scan that skips
// each leading zero digit and finds the first, then one digit out per cycle while not stalled
// one value at a time, o_stall high from load until the last digit is emitted; the time per
// value is set by the conversion loop and the digit scan, and output stalls add to it
// a new value is taken once the last digit sits in the output register
// synchronous active-low reset clears the control state and the output valid

module binary_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_ascii_digit,
    output logic        o_last
);
    import b2da_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [VALUE_BITS-1:0] r_shift;
    logic [VALUE_BITS-1:0] n_shift;
    logic [BIT_CNT_W-1:0]  r_bit_cnt;
    logic [BIT_CNT_W-1:0]  n_bit_cnt;
    logic [DIG_CNT_W-1:0]  r_dig_left;
    logic [DIG_CNT_W-1:0]  n_dig_left;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [5:0]            r_out_digit;
    logic [5:0]            n_out_digit;
    logic                  r_out_last;
    logic                  n_out_last;

    t_bcd_ctrl             w_ctrl;
    logic [3:0]            w_top_digit;
    logic                  w_in_accept;
    logic                  w_out_take;
    logic                  w_slot_free;
    logic                  w_conv_done;
    logic                  w_skip_zero;
    logic                  w_final_digit;

    b2da_bcd_shift u_bcd (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .o_top_digit (w_top_digit)
    );

    assign o_stall       = (r_state != ST_IDLE);
    assign w_in_accept   = i_valid && !o_stall;
    assign w_out_take    = r_out_valid && !i_stall;
    assign w_slot_free   = !r_out_valid || !i_stall;
    assign w_conv_done   = (r_bit_cnt == BIT_CNT_W'(VALUE_BITS - 1));
    assign w_final_digit = (r_dig_left == DIG_CNT_W'(1));
    // drop leading zero digits but always keep the units digit
    assign w_skip_zero   = (w_top_digit == 4'd0) && !w_final_digit;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (w_conv_done) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (!w_skip_zero) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_slot_free && w_final_digit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and output controls
    always_comb begin
        w_ctrl      = '0;
        n_shift     = r_shift;
        n_bit_cnt   = r_bit_cnt;
        n_dig_left  = r_dig_left;
        n_out_valid = r_out_valid && !w_out_take;
        n_out_digit = r_out_digit;
        n_out_last  = r_out_last;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    w_ctrl.clear = 1'b1;
                    n_shift      = i_value[VALUE_BITS-1:0];
                    n_bit_cnt    = '0;
                end
            end
            ST_CONV: begin
                w_ctrl.dabble = 1'b1;
                w_ctrl.bit_in = r_shift[VALUE_BITS-1];
                n_shift       = r_shift << 1;
                n_bit_cnt     = r_bit_cnt + 1'b1;
                n_dig_left    = DIG_CNT_W'(MAX_DIGITS);
            end
            ST_SKIP: begin
                if (w_skip_zero) begin
                    w_ctrl.shift_digit = 1'b1;
                    n_dig_left         = r_dig_left - 1'b1;
                end
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    w_ctrl.shift_digit = 1'b1;
                    n_dig_left         = r_dig_left - 1'b1;
                    n_out_valid        = 1'b1;
                    n_out_digit        = ASCII_ZERO + {2'b00, w_top_digit};
                    n_out_last         = w_final_digit;
                end
            end
            default: begin
                n_shift = r_shift;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_bit_cnt   <= '0;
            r_dig_left  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_bit_cnt   <= n_bit_cnt;
            r_dig_left  <= n_dig_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift     <= n_shift;
        r_out_digit <= n_out_digit;
        r_out_last  <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_ascii_digit = r_out_digit;
    assign o_last        = r_out_last;

endmodule
